// ===== sv/lcg48_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_pkg: shared types and constants of the 48-bit LCG generator
// Request and result structs, operation and status codes, and the fixed
// constants of the generator recurrence.
// ----------------------------------------------------------------------------
package lcg48_pkg;

    // Recurrence: state = state * LCG_MULT + LCG_ADD (mod 2^48)
    localparam int unsigned LCG_BITS = 48;
    localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [47:0] LCG_ADD = 48'hB;

    // Operation codes
    localparam logic [2:0] OP_RESEED = 3'd0;
    localparam logic [2:0] OP_RAW = 3'd1;
    localparam logic [2:0] OP_INT = 3'd2;
    localparam logic [2:0] OP_LONG = 3'd3;
    localparam logic [2:0] OP_BOOL = 3'd4;
    localparam logic [2:0] OP_MANT = 3'd5;

    // Status codes
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_BAD_ARG = 1'b1;

    // Draw widths
    localparam logic [5:0] K_BOOL = 6'd1;
    localparam logic [5:0] K_MANT_HI = 6'd26;
    localparam logic [5:0] K_MANT_LO = 6'd27;
    localparam logic [5:0] K_INT = 6'd31;
    localparam logic [5:0] K_MAX = 6'd32;

    typedef struct packed {
        logic [2:0]         op;
        logic [5:0]         bit_count;
        logic signed [31:0] bound;
    } lcg48_in_t;

    typedef struct packed {
        logic [63:0] value;
        logic        status;
    } lcg48_out_t;

endpackage
`default_nettype wire

// ===== sv/lcg48_random_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_random_generator: 48-bit linear congruential random generator
// Serves one request at a time: reseed, raw draw, bounded int, long,
// boolean or 53-bit mantissa, each answered with one result.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry requests; in_stall is high while a request
//   is being worked on. out_valid/out_stall/out_data carry results; a result
//   waits in the output register while out_stall is high, and the next request
//   is taken meanwhile but its result is held until the register is free.
//   cfg_valid/cfg_ready/cfg_data write the 64-bit seed; always ready.
// Sequence after request accept:
//   reseed or bad argument: straight to the result. Every state advance runs in
//   the shared 16x35 multiply-accumulate unit (one 16-bit state slice per
//   cycle). Raw draw and boolean: one advance. Long and mantissa: two advances.
//   Power-of-two bound: one advance and a multiply-shift. Other bounds: per draw
//   attempt, one advance, 31 restoring-divide steps and a rejection check;
//   a rejected draw repeats the attempt.
// A new request is taken only after the previous result has entered the output register.
// Reset: state = 0x5DEECE66D (zero seed scrambled), seed register = 0,
//   no result pending.
// ----------------------------------------------------------------------------
module lcg48_random_generator (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire lcg48_pkg::lcg48_in_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output lcg48_pkg::lcg48_out_t      out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [63:0]           cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POW2,
        S_DIV,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [47:0]            lcg_reg, lcg_next;
    logic [63:0]            seed_reg, seed_next;
    logic [47:0]            acc_reg, acc_next;
    logic [1:0]             idx_reg, idx_next;
    logic [2:0]             op_reg, op_next;
    logic [5:0]             k_reg, k_next;
    logic [30:0]            n_reg, n_next;
    logic                   phase_reg, phase_next;
    logic [31:0]            hi_reg, hi_next;
    logic [30:0]            draw_reg, draw_next;
    logic [30:0]            rem_reg, rem_next;
    logic [4:0]             cnt_reg, cnt_next;
    lcg48_pkg::lcg48_out_t  res_reg, res_next;
    lcg48_pkg::lcg48_out_t  out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [15:0]            chunk;
    logic [50:0]            mul_prod;
    logic [47:0]            mul_term;
    logic [47:0]            acc_sum;
    logic [31:0]            drawn;
    logic                   pow2;
    logic [62:0]            pw_prod;
    logic [31:0]            trial;
    logic [31:0]            chk;
    logic                   out_free;

    // Shared multiply-accumulate: one 16-bit state slice per cycle
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    chunk = lcg_reg[15:0];
            2'd1:    chunk = lcg_reg[31:16];
            default: chunk = lcg_reg[47:32];
        endcase
        mul_prod = 51'(chunk) * 51'(lcg48_pkg::LCG_MULT);
        unique case (idx_reg)
            2'd0:    mul_term = mul_prod[47:0];
            2'd1:    mul_term = {mul_prod[31:0], 16'b0};
            default: mul_term = {mul_prod[15:0], 32'b0};
        endcase
        acc_sum = acc_reg + mul_term;
    end

    // Top k bits of the new state
    assign drawn = 32'(acc_sum >> (6'(lcg48_pkg::LCG_BITS) - k_reg));

    // Bound helpers: power-of-two test, multiply-shift, divider step, rejection
    assign pow2 = (n_reg & (n_reg - 31'd1)) == 31'd0;
    assign pw_prod = 63'(n_reg) * 63'(draw_reg);
    assign trial = {rem_reg, draw_reg[cnt_reg]};
    assign chk = 32'(draw_reg) - 32'(rem_reg) + 32'(n_reg) - 32'd1;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer next-state logic
    always_comb
    begin
        state_next = state_reg;
        lcg_next = lcg_reg;
        acc_next = acc_reg;
        idx_next = idx_reg;
        op_next = op_reg;
        k_next = k_reg;
        n_next = n_reg;
        phase_next = phase_reg;
        hi_next = hi_reg;
        draw_next = draw_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        seed_next = cfg_valid ? cfg_data : seed_reg;

        // result taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_data.op;
                    phase_next = 1'b0;
                    acc_next = lcg48_pkg::LCG_ADD;
                    idx_next = 2'd0;
                    res_next.value = '0;
                    res_next.status = lcg48_pkg::STATUS_OK;
                    state_next = S_MUL;
                    unique case (in_data.op)
                        lcg48_pkg::OP_RESEED:
                        begin
                            lcg_next = 48'(seed_reg ^ 64'(lcg48_pkg::LCG_MULT));
                            state_next = S_DONE;
                        end
                        lcg48_pkg::OP_RAW:
                        begin
                            k_next = in_data.bit_count;
                            if (in_data.bit_count == 6'd0 || in_data.bit_count > lcg48_pkg::K_MAX)
                            begin
                                res_next.status = lcg48_pkg::STATUS_BAD_ARG;
                                state_next = S_DONE;
                            end
                        end
                        lcg48_pkg::OP_INT:
                        begin
                            k_next = lcg48_pkg::K_INT;
                            n_next = in_data.bound[30:0];
                            if (in_data.bound == 32'sd0 || in_data.bound[31])
                            begin
                                res_next.status = lcg48_pkg::STATUS_BAD_ARG;
                                state_next = S_DONE;
                            end
                        end
                        lcg48_pkg::OP_LONG: k_next = lcg48_pkg::K_MAX;
                        lcg48_pkg::OP_BOOL: k_next = lcg48_pkg::K_BOOL;
                        lcg48_pkg::OP_MANT: k_next = lcg48_pkg::K_MANT_HI;
                        default:
                        begin
                            res_next.status = lcg48_pkg::STATUS_BAD_ARG;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                acc_next = acc_sum;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    lcg_next = acc_sum;
                    state_next = S_DONE;
                    unique case (op_reg)
                        lcg48_pkg::OP_RAW, lcg48_pkg::OP_BOOL:
                        begin
                            res_next.value = 64'(drawn);
                        end
                        lcg48_pkg::OP_INT:
                        begin
                            draw_next = drawn[30:0];
                            rem_next = '0;
                            cnt_next = 5'd30;
                            state_next = pow2 ? S_POW2 : S_DIV;
                        end
                        lcg48_pkg::OP_LONG:
                        begin
                            if (!phase_reg)
                            begin
                                hi_next = drawn;
                                phase_next = 1'b1;
                                acc_next = lcg48_pkg::LCG_ADD;
                                idx_next = 2'd0;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                res_next.value = {hi_reg, 32'b0} + {{32{drawn[31]}}, drawn};
                            end
                        end
                        lcg48_pkg::OP_MANT:
                        begin
                            if (!phase_reg)
                            begin
                                hi_next = drawn;
                                k_next = lcg48_pkg::K_MANT_LO;
                                phase_next = 1'b1;
                                acc_next = lcg48_pkg::LCG_ADD;
                                idx_next = 2'd0;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                res_next.value = 64'({hi_reg[25:0], drawn[26:0]});
                            end
                        end
                        default:
                        begin
                            res_next.status = lcg48_pkg::STATUS_BAD_ARG;
                        end
                    endcase
                end
            end

            // n is 2^j: (n * r) >> 31
            S_POW2:
            begin
                res_next.value = 64'(pw_prod[62:31]);
                state_next = S_DONE;
            end

            // restoring division, one quotient bit per cycle
            S_DIV:
            begin
                if (trial >= {1'b0, n_reg})
                begin
                    rem_next = 31'(trial - {1'b0, n_reg});
                end
                else
                begin
                    rem_next = trial[30:0];
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_CHECK;
                end
            end

            // reject draws from the incomplete last band
            S_CHECK:
            begin
                if (chk[31])
                begin
                    acc_next = lcg48_pkg::LCG_ADD;
                    idx_next = 2'd0;
                    state_next = S_MUL;
                end
                else
                begin
                    res_next.value = 64'(rem_reg);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lcg_reg <= 48'(lcg48_pkg::LCG_MULT);
            seed_reg <= '0;
            acc_reg <= '0;
            idx_reg <= '0;
            op_reg <= '0;
            k_reg <= '0;
            n_reg <= '0;
            phase_reg <= 1'b0;
            hi_reg <= '0;
            draw_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            res_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lcg_reg <= lcg_next;
            seed_reg <= seed_next;
            acc_reg <= acc_next;
            idx_reg <= idx_next;
            op_reg <= op_next;
            k_reg <= k_next;
            n_reg <= n_next;
            phase_reg <= phase_next;
            hi_reg <= hi_next;
            draw_reg <= draw_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
            res_reg <= res_next;
            out_reg <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    // an accepted request keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after request accept");

    // a new result only appears out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    // an error result carries a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == lcg48_pkg::STATUS_BAD_ARG) |->
        out_data.value == 64'd0)
        else $error("error result with nonzero value");

    // divider remainder stays below the bound
    a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (rem_reg < n_reg))
        else $error("remainder not below bound");
`endif

endmodule
`default_nettype wire
